// ----- rtl/cvg_pkg.sv -----
package cvg_pkg;

	// fixed field and datapath widths
	localparam int POINT_W     = 48;
	localparam int MAG_W       = POINT_W - 1;
	localparam int FACTOR_W    = 32;
	localparam int FACTOR_FRAC = 30;
	localparam int PIXEL_W     = 16;
	localparam int RADIUS_W    = 15;
	localparam int SEG_W       = 7;
	localparam int CFG_IDX_W   = 2;

	// point magnitude limit, 2^47-1
	localparam logic [MAG_W-1:0] POINT_LIMIT = '1;

	localparam logic [SEG_W-1:0] MIN_SEGMENTS = 7'd3;

	// register reset values
	localparam logic [SEG_W-1:0]    SEGMENT_COUNT_RST  = 7'd64;
	localparam logic [FACTOR_W-1:0] TANGENT_FACTOR_RST = 32'd105754350;
	localparam logic [FACTOR_W-1:0] RADIAL_FACTOR_RST  = 32'd1068571424;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENT_COUNT  = 2'd0,
		REG_TANGENT_FACTOR = 2'd1,
		REG_RADIAL_FACTOR  = 2'd2
	} cfg_reg_t;

	// controller states, one vertex takes EMIT through SCALE_Y
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_TAN_X,
		ST_ADD_X,
		ST_ADD_Y,
		ST_RAD_Y,
		ST_SCALE_X,
		ST_SCALE_Y
	} ctrl_state_t;

	// point register operation
	typedef enum logic [2:0] {
		PT_HOLD,
		PT_LOAD,
		PT_ADD_X,
		PT_ADD_Y,
		PT_SCALE_X,
		PT_SCALE_Y
	} pt_op_t;

	// multiplier operand select
	typedef enum logic [1:0] {
		OPND_NEG_Y,
		OPND_X,
		OPND_Y
	} mul_opnd_t;

	typedef struct packed {
		pt_op_t    pt_op;
		mul_opnd_t mul_opnd;
		logic      mul_radial;
		logic      emit;
		logic      last;
	} dp_cmd_t;

endpackage

// ----- rtl/circle_vertex_generator_core.sv -----
// Circle vertex generator. Pulse start with center and radius while busy is
// low; the block then produces segment_count vertices (clamped to
// 3..MAX_SEGMENTS), each shown for one cycle with vertex_valid high, the
// final one with last_vertex set. The receiver cannot stall: every vertex
// must be taken the cycle it appears. A taken start moves the controller
// to EMIT, and its strobe goes through emit_s1 and vertex_valid to show
// the first vertex; each later vertex takes one pass from TAN_X through
// SCALE_Y back to EMIT. Busy stays high from the first EMIT state through
// the last one. The vertex pacing comes from the single shared two-stage
// factor multiplier, used four times per vertex (tangent step on x and y,
// radial pull on x and y). Factor registers are written through the cfg
// channel, which is always ready, and must only be written while busy is low.
module circle_vertex_generator_core #(
	parameter int MAX_SEGMENTS        = 64,
	parameter int POINT_FRACTION_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [cvg_pkg::PIXEL_W-1:0]   center_x,
	input  logic signed [cvg_pkg::PIXEL_W-1:0]   center_y,
	input  logic        [cvg_pkg::RADIUS_W-1:0]  radius,
	output logic                                 vertex_valid,
	output logic signed [cvg_pkg::PIXEL_W-1:0]   vertex_x,
	output logic signed [cvg_pkg::PIXEL_W-1:0]   vertex_y,
	output logic                                 last_vertex,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [cvg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [cvg_pkg::FACTOR_W-1:0]  cfg_data
);

	logic [cvg_pkg::SEG_W-1:0]           segment_count_q;
	logic signed [cvg_pkg::FACTOR_W-1:0] tangent_factor_q;
	logic signed [cvg_pkg::FACTOR_W-1:0] radial_factor_q;
	cvg_pkg::dp_cmd_t                    cmd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q  <= cvg_pkg::SEGMENT_COUNT_RST;
			tangent_factor_q <= cvg_pkg::TANGENT_FACTOR_RST;
			radial_factor_q  <= cvg_pkg::RADIAL_FACTOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cvg_pkg::REG_SEGMENT_COUNT:  segment_count_q  <= cfg_data[cvg_pkg::SEG_W-1:0];
				cvg_pkg::REG_TANGENT_FACTOR: tangent_factor_q <= cfg_data;
				cvg_pkg::REG_RADIAL_FACTOR:  radial_factor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	cvg_ctrl #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.segment_count (segment_count_q),
		.busy          (busy),
		.cmd           (cmd)
	);

	cvg_datapath #(
		.POINT_FRACTION_BITS (POINT_FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.center_x       (center_x),
		.center_y       (center_y),
		.radius         (radius),
		.tangent_factor (tangent_factor_q),
		.radial_factor  (radial_factor_q),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.last_vertex    (last_vertex),
		.vertex_valid   (vertex_valid)
	);

endmodule

// ----- rtl/cvg_mul.sv -----
// Two-stage point-by-factor multiplier: |a|*|f| / 2^30, rounded half away
// from zero, saturated to the point limit. Result is sign and magnitude.
module cvg_mul (
	input  logic                                 clk,
	input  logic signed [cvg_pkg::POINT_W-1:0]   operand,
	input  logic signed [cvg_pkg::FACTOR_W-1:0]  factor,
	output logic        [cvg_pkg::MAG_W-1:0]     mag,
	output logic                                 neg
);

	localparam int LO_W   = 24;
	localparam int HI_W   = cvg_pkg::MAG_W - LO_W;
	localparam int PH_W   = HI_W + cvg_pkg::FACTOR_W;
	localparam int PL_W   = LO_W + cvg_pkg::FACTOR_W;
	localparam int FULL_W = PH_W + LO_W + 1;
	localparam int R_W    = FULL_W - cvg_pkg::FACTOR_FRAC;
	localparam logic [FULL_W-1:0] HALF = FULL_W'(1) << (cvg_pkg::FACTOR_FRAC - 1);

	logic [cvg_pkg::POINT_W-1:0]  a_abs;
	logic [cvg_pkg::MAG_W-1:0]    a_mag;
	logic [cvg_pkg::FACTOR_W-1:0] f_abs;
	logic [PH_W-1:0]              hi_s1;
	logic [PL_W-1:0]              lo_s1;
	logic                         neg_s1;
	logic [FULL_W-1:0]            full;
	logic [R_W-1:0]               rnd;
	logic [cvg_pkg::MAG_W-1:0]    mag_s2;
	logic                         neg_s2;

	// magnitudes; the point never reaches -2^47 so 47 bits hold it
	always_comb begin
		a_abs = operand[cvg_pkg::POINT_W-1] ? -operand : operand;
		a_mag = a_abs[cvg_pkg::MAG_W-1:0];
		f_abs = factor[cvg_pkg::FACTOR_W-1] ? -factor : factor;
	end

	// stage 1: two partial products, upper and lower slice of |a|
	always_ff @(posedge clk) begin
		hi_s1  <= PH_W'(a_mag[cvg_pkg::MAG_W-1:LO_W]) * PH_W'(f_abs);
		lo_s1  <= PL_W'(a_mag[LO_W-1:0]) * PL_W'(f_abs);
		neg_s1 <= operand[cvg_pkg::POINT_W-1] ^ factor[cvg_pkg::FACTOR_W-1];
	end

	// stage 2: combine, round, saturate
	always_comb begin
		full = FULL_W'({hi_s1, {LO_W{1'b0}}}) + FULL_W'(lo_s1) + HALF;
		rnd  = full[FULL_W-1:cvg_pkg::FACTOR_FRAC];
	end

	always_ff @(posedge clk) begin
		if (rnd > R_W'(cvg_pkg::POINT_LIMIT)) begin
			mag_s2 <= cvg_pkg::POINT_LIMIT;
		end else begin
			mag_s2 <= rnd[cvg_pkg::MAG_W-1:0];
		end
		neg_s2 <= neg_s1;
	end

	assign mag = mag_s2;
	assign neg = neg_s2;

endmodule

// ----- rtl/cvg_datapath.sv -----
// Point registers, factor multiplier and the two-stage pixel output path.
module cvg_datapath #(
	parameter int POINT_FRACTION_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cvg_pkg::dp_cmd_t                     cmd,
	input  logic signed [cvg_pkg::PIXEL_W-1:0]   center_x,
	input  logic signed [cvg_pkg::PIXEL_W-1:0]   center_y,
	input  logic        [cvg_pkg::RADIUS_W-1:0]  radius,
	input  logic signed [cvg_pkg::FACTOR_W-1:0]  tangent_factor,
	input  logic signed [cvg_pkg::FACTOR_W-1:0]  radial_factor,
	output logic signed [cvg_pkg::PIXEL_W-1:0]   vertex_x,
	output logic signed [cvg_pkg::PIXEL_W-1:0]   vertex_y,
	output logic                                 last_vertex,
	output logic                                 vertex_valid
);

	localparam int PW    = cvg_pkg::POINT_W;
	localparam int RND_W = PW - POINT_FRACTION_BITS;
	localparam int PIX_W = RND_W + 2;
	localparam logic [PW-1:0] PIX_HALF = PW'(1) << (POINT_FRACTION_BITS - 1);

	logic signed [PW-1:0]                  point_x_q, point_y_q;
	logic signed [cvg_pkg::PIXEL_W-1:0]    center_x_q, center_y_q;
	logic signed [PW-1:0]                  mul_a;
	logic signed [cvg_pkg::FACTOR_W-1:0]   mul_f;
	logic        [cvg_pkg::MAG_W-1:0]      mul_mag;
	logic                                  mul_neg;
	logic        [PW-1:0]                  abs_x, abs_y, rsum_x, rsum_y;
	logic        [RND_W-1:0]               rx_s1, ry_s1;
	logic                                  nx_s1, ny_s1, emit_s1, last_s1;
	logic signed [cvg_pkg::PIXEL_W-1:0]    vertex_x_q, vertex_y_q;
	logic                                  last_vertex_q, vertex_valid_q;

	// signed value from the multiplier's sign and magnitude
	function automatic logic signed [PW-1:0] signed_of(
		input logic [cvg_pkg::MAG_W-1:0] m,
		input logic                      n
	);
		logic signed [PW-1:0] v;
		v = $signed({1'b0, m});
		return n ? -v : v;
	endfunction

	// point plus product, saturated to +-(2^47-1)
	function automatic logic signed [PW-1:0] add_sat(
		input logic signed [PW-1:0]      p,
		input logic [cvg_pkg::MAG_W-1:0] m,
		input logic                      n
	);
		logic signed [PW:0] sum;
		logic signed [PW:0] lim;
		sum = $signed({p[PW-1], p}) + $signed({2'b00, m}) * 0
			+ (n ? -$signed({2'b00, m}) : $signed({2'b00, m}));
		lim = $signed({2'b00, cvg_pkg::POINT_LIMIT});
		if (sum > lim) begin
			return lim[PW-1:0];
		end else if (sum < -lim) begin
			return -lim[PW-1:0];
		end
		return sum[PW-1:0];
	endfunction

	// rounded magnitude plus center, saturated to a 16-bit pixel
	function automatic logic signed [cvg_pkg::PIXEL_W-1:0] pix_sat(
		input logic [RND_W-1:0]                 r,
		input logic                             n,
		input logic signed [cvg_pkg::PIXEL_W-1:0] c
	);
		logic signed [PIX_W-1:0] v;
		v = $signed({2'b00, r});
		if (n) begin
			v = -v;
		end
		v = v + $signed({{(PIX_W - cvg_pkg::PIXEL_W){c[cvg_pkg::PIXEL_W-1]}}, c});
		if (v > PIX_W'(32767)) begin
			return 16'sd32767;
		end else if (v < -PIX_W'(32768)) begin
			return -16'sd32768;
		end
		return v[cvg_pkg::PIXEL_W-1:0];
	endfunction

	// multiplier operand and factor select
	always_comb begin
		case (cmd.mul_opnd)
			cvg_pkg::OPND_NEG_Y: mul_a = -point_y_q;
			cvg_pkg::OPND_X:     mul_a = point_x_q;
			cvg_pkg::OPND_Y:     mul_a = point_y_q;
			default:             mul_a = point_x_q;
		endcase
		mul_f = cmd.mul_radial ? radial_factor : tangent_factor;
	end

	cvg_mul u_mul (
		.clk     (clk),
		.operand (mul_a),
		.factor  (mul_f),
		.mag     (mul_mag),
		.neg     (mul_neg)
	);

	// running point and held center
	always_ff @(posedge clk) begin
		case (cmd.pt_op)
			cvg_pkg::PT_LOAD: begin
				point_x_q  <= $signed(PW'(radius) << POINT_FRACTION_BITS);
				point_y_q  <= '0;
				center_x_q <= center_x;
				center_y_q <= center_y;
			end
			cvg_pkg::PT_ADD_X:   point_x_q <= add_sat(point_x_q, mul_mag, mul_neg);
			cvg_pkg::PT_ADD_Y:   point_y_q <= add_sat(point_y_q, mul_mag, mul_neg);
			cvg_pkg::PT_SCALE_X: point_x_q <= signed_of(mul_mag, mul_neg);
			cvg_pkg::PT_SCALE_Y: point_y_q <= signed_of(mul_mag, mul_neg);
			default: ;
		endcase
	end

	// pixel stage 1: round the magnitude to whole pixels
	always_comb begin
		abs_x  = point_x_q[PW-1] ? -point_x_q : point_x_q;
		abs_y  = point_y_q[PW-1] ? -point_y_q : point_y_q;
		rsum_x = abs_x + PIX_HALF;
		rsum_y = abs_y + PIX_HALF;
	end

	always_ff @(posedge clk) begin
		rx_s1   <= rsum_x[PW-1:POINT_FRACTION_BITS];
		ry_s1   <= rsum_y[PW-1:POINT_FRACTION_BITS];
		nx_s1   <= point_x_q[PW-1];
		ny_s1   <= point_y_q[PW-1];
		last_s1 <= cmd.last;
	end

	// pixel stage 2: sign, center, saturate
	always_ff @(posedge clk) begin
		vertex_x_q    <= pix_sat(rx_s1, nx_s1, center_x_q);
		vertex_y_q    <= pix_sat(ry_s1, ny_s1, center_y_q);
		last_vertex_q <= last_s1;
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1        <= 1'b0;
			vertex_valid_q <= 1'b0;
		end else begin
			emit_s1        <= cmd.emit;
			vertex_valid_q <= emit_s1;
		end
	end

	assign vertex_x     = vertex_x_q;
	assign vertex_y     = vertex_y_q;
	assign last_vertex  = last_vertex_q;
	assign vertex_valid = vertex_valid_q;

endmodule

// ----- rtl/cvg_ctrl.sv -----
// Sequencer: seven steps per vertex, counts vertices of the circle.
module cvg_ctrl #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cvg_pkg::SEG_W-1:0]     segment_count,
	output logic                          busy,
	output cvg_pkg::dp_cmd_t              cmd
);

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	cvg_pkg::ctrl_state_t        state_q, state_nxt;
	logic [CNT_W-1:0]            idx_q, count_q;
	logic [cvg_pkg::SEG_W-1:0]   seg_clamped;
	logic                        accept, is_last;

	assign busy    = (state_q != cvg_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign is_last = (idx_q == count_q - CNT_W'(1));

	// clamp the vertex count into 3..MAX_SEGMENTS
	always_comb begin
		if (segment_count < cvg_pkg::MIN_SEGMENTS) begin
			seg_clamped = cvg_pkg::MIN_SEGMENTS;
		end else if (segment_count > cvg_pkg::SEG_W'(MAX_SEGMENTS)) begin
			seg_clamped = cvg_pkg::SEG_W'(MAX_SEGMENTS);
		end else begin
			seg_clamped = segment_count;
		end
	end

	// state, vertex index, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvg_pkg::ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				idx_q   <= '0;
				count_q <= seg_clamped[CNT_W-1:0];
			end else if (state_q == cvg_pkg::ST_EMIT) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		case (state_q)
			cvg_pkg::ST_IDLE:    state_nxt = start ? cvg_pkg::ST_EMIT : cvg_pkg::ST_IDLE;
			cvg_pkg::ST_EMIT:    state_nxt = is_last ? cvg_pkg::ST_IDLE : cvg_pkg::ST_TAN_X;
			cvg_pkg::ST_TAN_X:   state_nxt = cvg_pkg::ST_ADD_X;
			cvg_pkg::ST_ADD_X:   state_nxt = cvg_pkg::ST_ADD_Y;
			cvg_pkg::ST_ADD_Y:   state_nxt = cvg_pkg::ST_RAD_Y;
			cvg_pkg::ST_RAD_Y:   state_nxt = cvg_pkg::ST_SCALE_X;
			cvg_pkg::ST_SCALE_X: state_nxt = cvg_pkg::ST_SCALE_Y;
			cvg_pkg::ST_SCALE_Y: state_nxt = cvg_pkg::ST_EMIT;
			default:             state_nxt = cvg_pkg::ST_IDLE;
		endcase
	end

	// datapath commands; a product issued here passes both multiplier registers before a later state uses it
	always_comb begin
		cmd.pt_op      = cvg_pkg::PT_HOLD;
		cmd.mul_opnd   = cvg_pkg::OPND_X;
		cmd.mul_radial = 1'b0;
		cmd.emit       = 1'b0;
		cmd.last       = 1'b0;
		case (state_q)
			cvg_pkg::ST_IDLE: begin
				if (start) begin
					cmd.pt_op = cvg_pkg::PT_LOAD;
				end
			end
			cvg_pkg::ST_EMIT: begin
				cmd.emit     = 1'b1;
				cmd.last     = is_last;
				cmd.mul_opnd = cvg_pkg::OPND_NEG_Y;
			end
			cvg_pkg::ST_TAN_X: begin
				cmd.mul_opnd = cvg_pkg::OPND_X;
			end
			cvg_pkg::ST_ADD_X: begin
				cmd.pt_op = cvg_pkg::PT_ADD_X;
			end
			cvg_pkg::ST_ADD_Y: begin
				cmd.pt_op      = cvg_pkg::PT_ADD_Y;
				cmd.mul_opnd   = cvg_pkg::OPND_X;
				cmd.mul_radial = 1'b1;
			end
			cvg_pkg::ST_RAD_Y: begin
				cmd.mul_opnd   = cvg_pkg::OPND_Y;
				cmd.mul_radial = 1'b1;
			end
			cvg_pkg::ST_SCALE_X: begin
				cmd.pt_op = cvg_pkg::PT_SCALE_X;
			end
			cvg_pkg::ST_SCALE_Y: begin
				cmd.pt_op = cvg_pkg::PT_SCALE_Y;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/cvg_checker.sv -----
// Port-level checks on request and vertex timing.
module cvg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic vertex_valid,
	input logic last_vertex
);

	// a taken request makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// a taken request is followed by the first vertex beat
	a_first_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 vertex_valid)
		else $error("first vertex missing");

	// vertex beats never come back to back
	a_beat_gap: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |=> !vertex_valid)
		else $error("vertex beats back to back");

	// going idle is followed by the final vertex beat
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ##1 (vertex_valid && last_vertex))
		else $error("final vertex missing after going idle");

endmodule

bind circle_vertex_generator_core cvg_checker u_cvg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.vertex_valid (vertex_valid),
	.last_vertex  (last_vertex)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;

	localparam int MAX_VERTS  = 64;
	localparam int FRAC       = 30;
	localparam longint POINT_MAX = (longint'(1) << 47) - 1;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 8;
	localparam int N_ROWS     = 20;
	localparam int N_PHASES   = 8;
	localparam int PHASE_ITEMS = 10;
	localparam real PI_C      = 3.1415926;
	localparam real Q30       = 1073741824.0;
	// index 3 maps to no register, writes there must be ignored
	localparam logic [cvg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [cvg_pkg::PIXEL_W-1:0] x;
		logic signed [cvg_pkg::PIXEL_W-1:0] y;
		logic                               last;
	} vertex_t;

	typedef struct packed {
		logic                                cfg_en;
		logic [cvg_pkg::SEG_W-1:0]           seg;
		logic [cvg_pkg::FACTOR_W-1:0]        tan_f;
		logic [cvg_pkg::FACTOR_W-1:0]        rad_f;
		logic signed [cvg_pkg::PIXEL_W-1:0]  cx;
		logic signed [cvg_pkg::PIXEL_W-1:0]  cy;
		logic [cvg_pkg::RADIUS_W-1:0]        r;
		logic                                typed;
		logic signed [cvg_pkg::PIXEL_W-1:0]  ex;
		logic signed [cvg_pkg::PIXEL_W-1:0]  ey;
	} circle_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [cvg_pkg::PIXEL_W-1:0] center_x;
	logic signed [cvg_pkg::PIXEL_W-1:0] center_y;
	logic [cvg_pkg::RADIUS_W-1:0] radius;
	logic vertex_valid;
	logic signed [cvg_pkg::PIXEL_W-1:0] vertex_x;
	logic signed [cvg_pkg::PIXEL_W-1:0] vertex_y;
	logic last_vertex;
	logic cfg_valid;
	logic cfg_ready;
	logic [cvg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cvg_pkg::FACTOR_W-1:0] cfg_data;

	// register shadow copies used by the vertex predictor
	logic [cvg_pkg::SEG_W-1:0] seg_setting;
	logic signed [cvg_pkg::FACTOR_W-1:0] tan_setting;
	logic signed [cvg_pkg::FACTOR_W-1:0] rad_setting;

	vertex_t pending_vertices[$];

	int fail_count = 0;
	int vertices_checked = 0;
	int circles_sent = 0;
	int settings_used = 0;
	int sender_idle_pct = 0;
	int idle_cycles = 0;
	int phase_idle[4] = '{0, 59, 0, 23};

	// directed circles; first vertex typed in where it is obvious
	circle_row_t circle_rows[N_ROWS] = '{
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sd0, 16'sd0, 15'd0, 1'b1, 16'sd0, 16'sd0},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sd0, 16'sd0, 15'h7FFF, 1'b1, 16'sh7FFF, 16'sd0},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sh7FFF, 16'sh8000, 15'h7FFF, 1'b1,
			16'sh7FFF, 16'sh8000},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sh8000, 16'sh7FFF, 15'd100, 1'b1,
			-16'sd32668, 16'sh7FFF},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sh8000, 16'sh8000, 15'd0, 1'b1,
			16'sh8000, 16'sh8000},
		'{1'b0, 7'd0, 32'd0, 32'd0, -16'sd1, 16'sd1, 15'h7FFF, 1'b1, 16'sd32766, 16'sd1},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sd12, -16'sd34, 15'd5000, 1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd0, -32'sd1859775393, -32'sd536870912, 16'sd100, -16'sd100, 15'd1000,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd1, -32'sd1859775393, -32'sd536870912, 16'sd0, 16'sd0, 15'h7FFF,
			1'b1, 16'sh7FFF, 16'sd0},
		'{1'b1, 7'd2, -32'sd1859775393, -32'sd536870912, 16'sd7, 16'sd7, 15'd777,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd0, 16'sd0, 15'h7FFF,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd64, 32'h80000000, 32'h80000000, 16'sd0, 16'sd0, 15'h7FFF,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd65, 32'd0, 32'd0, -16'sd1, 16'sd1, 15'h7FFF, 1'b1, 16'sd32766, 16'sd1},
		'{1'b1, 7'd127, 32'h80000000, 32'h7FFFFFFF, 16'sd300, -16'sd300, 15'd20000,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd8, 32'd1073741824, 32'd759250125, 16'sd0, 16'sd0, 15'd1000,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd6, 32'd1859775393, 32'd536870912, 16'sd30000, -16'sd30000, 15'd20000,
			1'b0, 16'sd0, 16'sd0},
		'{1'b1, 7'd4, 32'h7FFFFFFF, 32'd0, 16'sd0, 16'sd0, 15'd5000, 1'b0, 16'sd0, 16'sd0},
		'{1'b1, cvg_pkg::SEGMENT_COUNT_RST, cvg_pkg::TANGENT_FACTOR_RST,
			cvg_pkg::RADIAL_FACTOR_RST, 16'sd5, 16'sd5, 15'd1, 1'b0, 16'sd0, 16'sd0},
		'{1'b0, 7'd0, 32'd0, 32'd0, 16'sh8000, 16'sh8000, 15'h7FFF, 1'b1,
			-16'sd1, 16'sh8000},
		'{1'b1, 7'd64, -32'sd105754350, cvg_pkg::RADIAL_FACTOR_RST, 16'sd1000, 16'sd2000,
			15'd12345, 1'b0, 16'sd0, 16'sd0}
	};

	circle_vertex_generator_core #(
		.MAX_SEGMENTS(MAX_VERTS),
		.POINT_FRACTION_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.vertex_valid(vertex_valid),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// point saturation to +/-(2^47-1)
	function automatic longint clamp_point(longint v);
		if (v > POINT_MAX) return POINT_MAX;
		if (v < -POINT_MAX) return -POINT_MAX;
		return v;
	endfunction

	// point times Q2.30 factor, round half away from zero, saturate
	function automatic longint factor_product(longint a,
			logic signed [cvg_pkg::FACTOR_W-1:0] f);
		logic neg;
		logic [95:0] am;
		logic [95:0] fm;
		logic [95:0] prod;
		neg = (a < 0) != (f < 0);
		am = 96'((a < 0) ? -a : a);
		fm = 96'((f < 0) ? -longint'(f) : longint'(f));
		prod = (am * fm + (96'd1 << (cvg_pkg::FACTOR_FRAC - 1))) >> cvg_pkg::FACTOR_FRAC;
		if (prod > POINT_MAX) prod = 96'(POINT_MAX);
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// round point to whole pixel, add center, saturate to 16 bits
	function automatic logic signed [cvg_pkg::PIXEL_W-1:0] point_to_pixel(longint p,
			logic signed [cvg_pkg::PIXEL_W-1:0] c);
		longint mag;
		longint v;
		mag = (p < 0) ? -p : p;
		v = (mag + (longint'(1) << (FRAC - 1))) >> FRAC;
		if (p < 0) v = -v;
		v = v + c;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[cvg_pkg::PIXEL_W-1:0];
	endfunction

	// walk one circle and queue its vertices; returns vertex count
	function automatic int trace_circle(logic signed [cvg_pkg::PIXEL_W-1:0] cx,
			logic signed [cvg_pkg::PIXEL_W-1:0] cy, logic [cvg_pkg::RADIUS_W-1:0] r);
		int count;
		longint px;
		longint py;
		longint old_x;
		longint old_y;
		vertex_t v;
		count = int'(seg_setting);
		if (count < cvg_pkg::MIN_SEGMENTS) count = int'(cvg_pkg::MIN_SEGMENTS);
		if (count > MAX_VERTS) count = MAX_VERTS;
		px = longint'(r) << FRAC;
		py = 0;
		for (int i = 0; i < count; i++) begin
			v.x = point_to_pixel(px, cx);
			v.y = point_to_pixel(py, cy);
			v.last = (i == count - 1);
			pending_vertices.push_back(v);
			old_x = px;
			old_y = py;
			px = clamp_point(old_x + factor_product(-old_y, tan_setting));
			py = clamp_point(old_y + factor_product(old_x, tan_setting));
			px = factor_product(px, rad_setting);
			py = factor_product(py, rad_setting);
		end
		return count;
	endfunction

	// one request beat; idles at random first, holds start until taken
	task automatic send_circle(input logic signed [cvg_pkg::PIXEL_W-1:0] cx,
			input logic signed [cvg_pkg::PIXEL_W-1:0] cy,
			input logic [cvg_pkg::RADIUS_W-1:0] r, output int n_vertices);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			center_x <= 16'($urandom);
			center_y <= 16'($urandom);
			radius <= 15'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		do @(posedge clk); while (busy);
		n_vertices = trace_circle(cx, cy, r);
		circles_sent++;
	endtask

	// stop sending until every queued vertex is out and the block is idle
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// config beat; valid stays up so back-to-back writes do not glitch it
	task automatic write_reg(input logic [cvg_pkg::CFG_IDX_W-1:0] idx,
			input logic [cvg_pkg::FACTOR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cvg_pkg::REG_SEGMENT_COUNT: seg_setting = data[cvg_pkg::SEG_W-1:0];
			cvg_pkg::REG_TANGENT_FACTOR: tan_setting = data;
			cvg_pkg::REG_RADIAL_FACTOR: rad_setting = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [cvg_pkg::SEG_W-1:0] seg,
			input logic [cvg_pkg::FACTOR_W-1:0] tan_f,
			input logic [cvg_pkg::FACTOR_W-1:0] rad_f, input logic poke_unused);
		write_reg(cvg_pkg::REG_SEGMENT_COUNT,
			{{(cvg_pkg::FACTOR_W-cvg_pkg::SEG_W){1'b0}}, seg});
		write_reg(cvg_pkg::REG_TANGENT_FACTOR, tan_f);
		write_reg(cvg_pkg::REG_RADIAL_FACTOR, rad_f);
		if (poke_unused) write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// vertex checker, compares against the oldest queued vertex
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && vertex_valid) begin
			if (pending_vertices.size() == 0) begin
				$error("unexpected vertex: x=%0d y=%0d last=%0b",
					vertex_x, vertex_y, last_vertex);
				fail_count++;
			end else begin
				want = pending_vertices.pop_front();
				if (vertex_x !== want.x) begin
					$error("vertex_x: expected %0d, got %0d", want.x, vertex_x);
					fail_count++;
				end
				if (vertex_y !== want.y) begin
					$error("vertex_y: expected %0d, got %0d", want.y, vertex_y);
					fail_count++;
				end
				if (last_vertex !== want.last) begin
					$error("last_vertex: expected %0b, got %0b", want.last, last_vertex);
					fail_count++;
				end
				vertices_checked++;
			end
		end
	end

	// watchdog on cycles with no request or register beat
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		circle_row_t row;
		vertex_t v;
		int n;
		int k;
		int cnt;
		real angle;
		logic [cvg_pkg::SEG_W-1:0] seg;
		logic [cvg_pkg::FACTOR_W-1:0] tan_f;
		logic [cvg_pkg::FACTOR_W-1:0] rad_f;
		logic signed [cvg_pkg::PIXEL_W-1:0] cx;
		logic signed [cvg_pkg::PIXEL_W-1:0] cy;
		logic [cvg_pkg::RADIUS_W-1:0] r;

		arst_n <= 1'b0;
		start <= 1'b0;
		center_x <= '0;
		center_y <= '0;
		radius <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= cvg_pkg::REG_SEGMENT_COUNT;
		cfg_data <= '0;
		seg_setting = cvg_pkg::SEGMENT_COUNT_RST;
		tan_setting = cvg_pkg::TANGENT_FACTOR_RST;
		rad_setting = cvg_pkg::RADIAL_FACTOR_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed circles
		sender_idle_pct = 23;
		foreach (circle_rows[i]) begin
			row = circle_rows[i];
			if (row.cfg_en) begin
				wait_drained();
				configure(row.seg, row.tan_f, row.rad_f, 1'b0);
			end
			send_circle(row.cx, row.cy, row.r, n);
			if (row.typed) begin
				k = pending_vertices.size() - n;
				v = pending_vertices[k];
				v.x = row.ex;
				v.y = row.ey;
				pending_vertices[k] = v;
			end
		end

		// random phases, each with its own register setting and an idle rate from phase_idle
		for (int phase = 0; phase < N_PHASES; phase++) begin
			wait_drained();
			if ($urandom_range(3) != 0) begin
				// true circle factors, mostly few segments
				cnt = $urandom_range(1) ? $urandom_range(6, 12) : $urandom_range(3, 64);
				if (cnt == 4 || cnt == 5) cnt = 3;
				angle = 2.0 * PI_C / cnt;
				tan_f = $rtoi($tan(angle) * Q30);
				rad_f = $rtoi($cos(angle) * Q30);
				seg = 7'(cnt);
			end else begin
				seg = 7'($urandom_range(0, 12));
				if ($urandom_range(3) == 0) seg = 7'($urandom);
				tan_f = $urandom;
				rad_f = $urandom;
			end
			configure(seg, tan_f, rad_f, 1'($urandom_range(1)));
			sender_idle_pct = phase_idle[phase % 4];
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if ($urandom_range(9) == 0) wait_drained();
				case ($urandom_range(3))
					0: r = 15'($urandom_range(0, 15));
					1: r = 15'($urandom);
					2: r = $urandom_range(1) ? 15'h7FFF : 15'd0;
					default: r = 15'($urandom_range(100, 5000));
				endcase
				cx = 16'($urandom);
				cy = 16'($urandom);
				if ($urandom_range(7) == 0) cx = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				if ($urandom_range(7) == 0) cy = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				send_circle(cx, cy, r, n);
			end
		end

		wait_drained();
		repeat (2 * DRAIN_WAIT) @(posedge clk);
		$display("%0d circles sent, %0d vertices checked, %0d register settings",
			circles_sent, vertices_checked, settings_used);
		$display("covered clamped segment counts, factor extremes, saturation, random circles");
		if (fail_count == 0 && pending_vertices.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cvg_pkg.sv
rtl/cvg_mul.sv
rtl/cvg_datapath.sv
rtl/cvg_ctrl.sv
rtl/circle_vertex_generator_core.sv
rtl/cvg_checker.sv
sim/tb.sv
